// ===== rtl/pfla_pkg.sv =====
// Package for the free page stack allocator.
// Holds sizes, operation and status codes, controller states and the
// command and status bundles shared by the controller and the datapath.
`default_nettype none

package pfla_pkg;

    localparam int MAX_PAGES  = 32768;
    localparam int PAGE_SHIFT = 12;

    localparam int ADDR_W   = 40;
    localparam int FRAME_W  = ADDR_W - PAGE_SHIFT;
    localparam int IDX_W    = $clog2(MAX_PAGES);
    localparam int DEPTH_W  = IDX_W + 1;
    localparam int COUNT_W  = 16;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 64;

    localparam logic [ADDR_W-1:0] KERNEL_END_RST = 40'h00_8000_0000;
    localparam logic [ADDR_W-1:0] PHYS_TOP_RST   = 40'h00_8800_0000;

    typedef enum logic {
        REG_KERNEL_END = 1'b0,
        REG_PHYS_TOP   = 1'b1
    } t_reg_idx;

    typedef enum logic [OP_W-1:0] {
        OP_FREE  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_INIT  = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_BAD   = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_INIT
    } t_state;

    typedef struct packed {
        logic    capture;
        logic    push_addr;
        logic    push_cursor;
        logic    pop;
        logic    init_start;
        logic    load_out;
        logic    grant;
        t_status status;
    } t_dp_cmd;

    typedef struct packed {
        t_op  op;
        logic addr_bad;
        logic stack_empty;
        logic stack_full;
        logic init_more;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== rtl/pfla_req_if.sv =====
// Request channel of the free page stack allocator.
// Carries valid, ready, the operation and the page address; uses pfla_pkg.
`default_nettype none

interface pfla_req_if;
    logic                         valid;
    logic                         ready;
    logic [pfla_pkg::OP_W-1:0]    op;
    logic [pfla_pkg::ADDR_W-1:0]  page_address;

    modport source (output valid, output op, output page_address, input ready);
    modport sink   (input valid, input op, input page_address, output ready);
endinterface

`default_nettype wire

// ===== rtl/pfla_rsp_if.sv =====
// Response channel of the free page stack allocator.
// Carries valid, ready, status, granted address and free count; uses pfla_pkg.
`default_nettype none

interface pfla_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [pfla_pkg::STATUS_W-1:0]  status;
    logic [pfla_pkg::ADDR_W-1:0]    granted_address;
    logic [pfla_pkg::COUNT_W-1:0]   free_count;

    modport source (output valid, output status, output granted_address,
                    output free_count, input ready);
    modport sink   (input valid, input status, input granted_address,
                    input free_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/pfla_regs.sv =====
// APB-style register file for the managed range bounds.
// Holds kernel_end and phys_top; uses pfla_pkg for widths and reset values.
`default_nettype none

module pfla_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [pfla_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [pfla_pkg::PDATA_W-1:0]  pwdata,
    output logic      [pfla_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready,
    output logic      [pfla_pkg::ADDR_W-1:0]   o_kernel_end,
    output logic      [pfla_pkg::ADDR_W-1:0]   o_phys_top
);

    logic [pfla_pkg::ADDR_W-1:0] r_kernel_end;
    logic [pfla_pkg::ADDR_W-1:0] r_phys_top;
    logic                        w_wr;
    pfla_pkg::t_reg_idx          w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_idx  = pfla_pkg::t_reg_idx'(paddr[3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel_end <= pfla_pkg::KERNEL_END_RST;
            r_phys_top   <= pfla_pkg::PHYS_TOP_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                pfla_pkg::REG_KERNEL_END: r_kernel_end <= pwdata[pfla_pkg::ADDR_W-1:0];
                pfla_pkg::REG_PHYS_TOP:   r_phys_top   <= pwdata[pfla_pkg::ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            pfla_pkg::REG_KERNEL_END:
                prdata = pfla_pkg::PDATA_W'(r_kernel_end);
            pfla_pkg::REG_PHYS_TOP:
                prdata = pfla_pkg::PDATA_W'(r_phys_top);
            default:
                prdata = '0;
        endcase
    end

    assign o_kernel_end = r_kernel_end;
    assign o_phys_top   = r_phys_top;

endmodule

`default_nettype wire

// ===== rtl/pfla_dp.sv =====
// Datapath of the free page stack allocator: stack memory, depth, init
// cursor, address checks and the response register. Uses pfla_pkg.
`default_nettype none

module pfla_dp (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic [pfla_pkg::OP_W-1:0]       i_op,
    input  wire logic [pfla_pkg::ADDR_W-1:0]     i_page_address,
    input  wire logic [pfla_pkg::ADDR_W-1:0]     i_kernel_end,
    input  wire logic [pfla_pkg::ADDR_W-1:0]     i_phys_top,
    input  wire pfla_pkg::t_dp_cmd               i_cmd,
    output pfla_pkg::t_dp_stat                   o_stat,
    input  wire logic                            i_out_ready,
    output logic                                 o_out_valid,
    output logic      [pfla_pkg::STATUS_W-1:0]   o_status,
    output logic      [pfla_pkg::ADDR_W-1:0]     o_granted_address,
    output logic      [pfla_pkg::COUNT_W-1:0]    o_free_count
);

    localparam int CUR_W = pfla_pkg::FRAME_W + 1;

    logic [pfla_pkg::FRAME_W-1:0]  r_stack [pfla_pkg::MAX_PAGES];
    logic [pfla_pkg::FRAME_W-1:0]  r_rd;

    pfla_pkg::t_op                 r_op;
    logic [pfla_pkg::ADDR_W-1:0]   r_addr;
    logic [pfla_pkg::DEPTH_W-1:0]  r_depth;
    logic [pfla_pkg::DEPTH_W-1:0]  n_depth;
    logic [CUR_W-1:0]              r_cursor;
    logic [CUR_W-1:0]              w_cur_start;
    logic [CUR_W-1:0]              w_cur_limit;

    logic                          r_out_valid;
    pfla_pkg::t_status             r_status;
    logic [pfla_pkg::ADDR_W-1:0]   r_granted;
    logic [pfla_pkg::COUNT_W-1:0]  r_count;

    logic                          w_we;
    logic [pfla_pkg::IDX_W-1:0]    w_wr_idx;
    logic [pfla_pkg::IDX_W-1:0]    w_rd_idx;
    logic [pfla_pkg::FRAME_W-1:0]  w_wr_data;
    logic [pfla_pkg::DEPTH_W-1:0]  w_depth_m1;

    assign w_cur_start = {1'b0, i_kernel_end[pfla_pkg::ADDR_W-1:pfla_pkg::PAGE_SHIFT]}
                       + CUR_W'(|i_kernel_end[pfla_pkg::PAGE_SHIFT-1:0]);
    assign w_cur_limit = {1'b0, i_phys_top[pfla_pkg::ADDR_W-1:pfla_pkg::PAGE_SHIFT]};

    assign w_depth_m1 = r_depth - pfla_pkg::DEPTH_W'(1);
    assign w_rd_idx   = w_depth_m1[pfla_pkg::IDX_W-1:0];
    assign w_wr_idx   = r_depth[pfla_pkg::IDX_W-1:0];
    assign w_we       = i_cmd.push_addr || i_cmd.push_cursor;
    assign w_wr_data  = i_cmd.push_cursor ? r_cursor[pfla_pkg::FRAME_W-1:0]
                                          : r_addr[pfla_pkg::ADDR_W-1:pfla_pkg::PAGE_SHIFT];

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_stack[w_wr_idx] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_stack[w_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= pfla_pkg::t_op'(i_op);
            r_addr <= i_page_address;
        end
    end

    always_comb begin
        priority if (i_cmd.init_start) begin
            n_depth = '0;
        end else if (w_we) begin
            n_depth = r_depth + pfla_pkg::DEPTH_W'(1);
        end else if (i_cmd.pop) begin
            n_depth = w_depth_m1;
        end else begin
            n_depth = r_depth;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth  <= '0;
            r_cursor <= '0;
        end else begin
            r_depth <= n_depth;
            if (i_cmd.init_start) begin
                r_cursor <= w_cur_start;
            end else if (i_cmd.push_cursor) begin
                r_cursor <= r_cursor + CUR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_status  <= i_cmd.status;
            r_granted <= i_cmd.grant ? {r_rd, {pfla_pkg::PAGE_SHIFT{1'b0}}} : '0;
            r_count   <= pfla_pkg::COUNT_W'(n_depth);
        end
    end

    assign o_stat.op          = r_op;
    assign o_stat.addr_bad    = (|r_addr[pfla_pkg::PAGE_SHIFT-1:0])
                             || (r_addr < i_kernel_end)
                             || (r_addr >= i_phys_top);
    assign o_stat.stack_empty = (r_depth == '0);
    assign o_stat.stack_full  = (r_depth == pfla_pkg::DEPTH_W'(pfla_pkg::MAX_PAGES));
    assign o_stat.init_more   = (r_cursor < w_cur_limit);
    assign o_stat.out_free    = !r_out_valid || i_out_ready;

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_granted_address = r_granted;
    assign o_free_count      = r_count;

endmodule

`default_nettype wire

// ===== rtl/pfla_ctrl.sv =====
// Controller of the free page stack allocator: sequences free, allocate
// and the init walk. Drives datapath commands; uses pfla_pkg.
`default_nettype none

module pfla_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire pfla_pkg::t_dp_stat  i_stat,
    output pfla_pkg::t_dp_cmd        o_cmd
);

    pfla_pkg::t_state r_state;
    pfla_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pfla_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.status = pfla_pkg::ST_OK;
        unique case (r_state)
            pfla_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = pfla_pkg::S_EXEC;
                end
            end
            pfla_pkg::S_EXEC: begin
                unique case (i_stat.op)
                    pfla_pkg::OP_FREE: begin
                        if (i_stat.out_free) begin
                            o_cmd.load_out = 1'b1;
                            n_state        = pfla_pkg::S_IDLE;
                            priority if (i_stat.addr_bad) begin
                                o_cmd.status = pfla_pkg::ST_BAD;
                            end else if (i_stat.stack_full) begin
                                o_cmd.status = pfla_pkg::ST_FULL;
                            end else begin
                                o_cmd.push_addr = 1'b1;
                            end
                        end
                    end
                    pfla_pkg::OP_ALLOC: begin
                        if (i_stat.out_free) begin
                            o_cmd.load_out = 1'b1;
                            n_state        = pfla_pkg::S_IDLE;
                            if (i_stat.stack_empty) begin
                                o_cmd.status = pfla_pkg::ST_EMPTY;
                            end else begin
                                o_cmd.pop   = 1'b1;
                                o_cmd.grant = 1'b1;
                            end
                        end
                    end
                    pfla_pkg::OP_INIT: begin
                        o_cmd.init_start = 1'b1;
                        n_state          = pfla_pkg::S_INIT;
                    end
                    pfla_pkg::OP_NOP: begin
                        if (i_stat.out_free) begin
                            o_cmd.load_out = 1'b1;
                            n_state        = pfla_pkg::S_IDLE;
                        end
                    end
                    default: ;
                endcase
            end
            pfla_pkg::S_INIT: begin
                if (i_stat.init_more && !i_stat.stack_full) begin
                    o_cmd.push_cursor = 1'b1;
                end else if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.status   = i_stat.init_more ? pfla_pkg::ST_FULL : pfla_pkg::ST_OK;
                    n_state        = pfla_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pfla_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/page_free_list_allocator.sv =====
// Free page stack allocator: LIFO of free page frames with init walk.
// Instantiates pfla_regs, pfla_ctrl and pfla_dp; uses pfla_pkg, pfla_req_if
// and pfla_rsp_if.
//
// i_req carries one word per operation: op (free, allocate, init, nop) and
// the page address for free. o_rsp returns one word per request: status,
// granted address and the free page count after the operation. The
// APB-style port writes kernel_end (0x0) and phys_top (0x8); write them only
// while no request is in flight.
// Free, allocate and the no-op pass through the idle state, which accepts
// and captures the request, and the exec state, which checks it, updates the
// stack and loads the registered response word. The stack top is read
// through a registered memory port, so a pop has its data in the check cycle.
// Init empties the stack and starts the cursor in exec, then pushes pages at
// one write per cycle until the range ends or the stack is full, then responds.
// Reset empties the stack and loads the range defaults; the stack memory is
// not cleared, as only entries below the depth are read.
// While o_rsp.ready is low the response holds; the next request is accepted
// and waits in exec (init still pushes its pages), holding the input off.
`default_nettype none

module page_free_list_allocator (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    pfla_req_if.sink                           i_req,
    pfla_rsp_if.source                         o_rsp,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [pfla_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [pfla_pkg::PDATA_W-1:0]  pwdata,
    output logic      [pfla_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready
);

    logic [pfla_pkg::ADDR_W-1:0] w_kernel_end;
    logic [pfla_pkg::ADDR_W-1:0] w_phys_top;
    pfla_pkg::t_dp_cmd           w_cmd;
    pfla_pkg::t_dp_stat          w_stat;
    logic                        w_in_ready;

    pfla_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_kernel_end (w_kernel_end),
        .o_phys_top   (w_phys_top)
    );

    pfla_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    pfla_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_op              (i_req.op),
        .i_page_address    (i_req.page_address),
        .i_kernel_end      (w_kernel_end),
        .i_phys_top        (w_phys_top),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .i_out_ready       (o_rsp.ready),
        .o_out_valid       (o_rsp.valid),
        .o_status          (o_rsp.status),
        .o_granted_address (o_rsp.granted_address),
        .o_free_count      (o_rsp.free_count)
    );

    assign i_req.ready = w_in_ready;

endmodule

`default_nettype wire
